>>> rtl/core/socks_pkg.sv
// socks_pkg: shared types and codes for the socks5 request parser
// no dependencies; used by socks_step and socks5_request_parser
`timescale 1ns / 1ps

package socks_pkg;

   localparam int POS_W = 9;

   // address type codes on the wire
   localparam logic [7:0] ATYPE_IPV4   = 8'd1;
   localparam logic [7:0] ATYPE_DOMAIN = 8'd3;
   localparam logic [7:0] ATYPE_IPV6   = 8'd4;

   localparam logic [7:0] CMD_CONNECT = 8'd1;

   // result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_ATYPE   = 3'd1;
   localparam logic [2:0] ST_IPV6        = 3'd2;
   localparam logic [2:0] ST_ZERO_ADDR   = 3'd3;
   localparam logic [2:0] ST_BAD_DOMAIN  = 3'd4;
   localparam logic [2:0] ST_BAD_CMD     = 3'd5;

   // result kinds
   localparam logic KIND_NAME  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // address kinds in results
   localparam logic AKIND_IPV4   = 1'b0;
   localparam logic AKIND_DOMAIN = 1'b1;

   // first byte after the header; last bytes of the ipv4, ipv6 and longest domain requests
   localparam logic [POS_W-1:0] POS_HDR_END  = 9'd4;
   localparam logic [POS_W-1:0] POS_IPV4_END = 9'd9;
   localparam logic [POS_W-1:0] POS_IPV6_END = 9'd21;
   localparam logic [POS_W-1:0] POS_MAX      = 9'd261;

   typedef struct packed {
      logic [POS_W-1:0] byte_pos;
      logic [7:0]       command_code;
      logic [7:0]       atype_code;
      logic [7:0]       domain_count;
      logic [31:0]      address_accum;
      logic [15:0]      port_accum;
      logic [7:0]       name_len_count;
      logic             zero_byte_seen;
   } parse_state_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic        addr_kind;
      logic [31:0] ipv4_addr;
      logic [15:0] dest_port;
      logic [7:0]  name_byte;
      logic [7:0]  name_length;
   } rsp_type;

endpackage

>>> rtl/core/socks_step.sv
// socks_step: per-byte parse logic, next state and optional result
// depends on socks_pkg
`timescale 1ns / 1ps

module socks_step #(
   parameter int MAX_HOST_LEN = 128
) (
   input  socks_pkg::parse_state_type cur_state,
   input  logic [7:0]                 data_byte,
   input  logic                       restart,
   output socks_pkg::parse_state_type nxt_state,
   output logic                       emit,
   output socks_pkg::rsp_type         rsp
);

   localparam logic [socks_pkg::POS_W-1:0] HostLimit = socks_pkg::POS_W'(MAX_HOST_LEN);

   socks_pkg::parse_state_type st;
   logic [socks_pkg::POS_W-1:0] pos;
   logic [socks_pkg::POS_W-1:0] pos_inc;
   logic [socks_pkg::POS_W-1:0] name_end;
   logic [socks_pkg::POS_W-1:0] port_end;
   logic [31:0]                 addr_upd;
   logic [15:0]                 port_upd;
   logic                        too_long;

   always_comb begin
      st = restart ? '0 : cur_state;
      pos = st.byte_pos;
      pos_inc = pos + 9'd1;
      name_end = 9'd4 + {1'b0, st.domain_count};
      port_end = 9'd6 + {1'b0, st.domain_count};
      addr_upd = {st.address_accum[23:0], data_byte};
      port_upd = {st.port_accum[7:0], data_byte};
      too_long = {1'b0, st.domain_count} >= HostLimit;

      nxt_state = st;
      emit = 1'b0;
      rsp = '0;

      if (pos < socks_pkg::POS_HDR_END) begin
         if (pos == 9'd1) begin
            nxt_state.command_code = data_byte;
         end
         if (pos == 9'd3) begin
            nxt_state.atype_code = data_byte;
         end
         nxt_state.byte_pos = pos_inc;
      end else begin
         case (st.atype_code)
            socks_pkg::ATYPE_IPV4: begin
               if (pos <= 9'd7) begin
                  nxt_state.address_accum = addr_upd;
               end else begin
                  nxt_state.port_accum = port_upd;
               end
               if (pos < socks_pkg::POS_IPV4_END) begin
                  nxt_state.byte_pos = pos_inc;
               end else begin
                  emit = 1'b1;
                  rsp.kind = socks_pkg::KIND_FINAL;
                  rsp.addr_kind = socks_pkg::AKIND_IPV4;
                  rsp.ipv4_addr = st.address_accum;
                  rsp.dest_port = port_upd;
                  if (st.address_accum == '0 || port_upd == '0) begin
                     rsp.status = socks_pkg::ST_ZERO_ADDR;
                  end else if (st.command_code != socks_pkg::CMD_CONNECT) begin
                     rsp.status = socks_pkg::ST_BAD_CMD;
                  end else begin
                     rsp.status = socks_pkg::ST_OK;
                  end
                  nxt_state = '0;
               end
            end
            socks_pkg::ATYPE_IPV6: begin
               if (pos < socks_pkg::POS_IPV6_END) begin
                  nxt_state.byte_pos = pos_inc;
               end else begin
                  emit = 1'b1;
                  rsp.kind = socks_pkg::KIND_FINAL;
                  rsp.status = socks_pkg::ST_IPV6;
                  nxt_state = '0;
               end
            end
            socks_pkg::ATYPE_DOMAIN: begin
               if (pos == socks_pkg::POS_HDR_END) begin
                  nxt_state.domain_count = data_byte;
                  nxt_state.byte_pos = pos_inc;
               end else if (pos <= name_end) begin
                  nxt_state.byte_pos = pos_inc;
                  if (!too_long) begin
                     if (!st.zero_byte_seen) begin
                        if (data_byte == 8'd0) begin
                           nxt_state.zero_byte_seen = 1'b1;
                        end else begin
                           nxt_state.name_len_count = st.name_len_count + 8'd1;
                        end
                     end
                     emit = 1'b1;
                     rsp.kind = socks_pkg::KIND_NAME;
                     rsp.addr_kind = socks_pkg::AKIND_DOMAIN;
                     rsp.name_byte = data_byte;
                  end
               end else begin
                  nxt_state.port_accum = port_upd;
                  if (pos < port_end) begin
                     nxt_state.byte_pos = pos_inc;
                  end else begin
                     emit = 1'b1;
                     rsp.kind = socks_pkg::KIND_FINAL;
                     rsp.addr_kind = socks_pkg::AKIND_DOMAIN;
                     rsp.dest_port = port_upd;
                     if (too_long) begin
                        rsp.status = socks_pkg::ST_BAD_DOMAIN;
                     end else begin
                        rsp.status = (st.command_code != socks_pkg::CMD_CONNECT) ?
                                     socks_pkg::ST_BAD_CMD : socks_pkg::ST_OK;
                        rsp.name_length = st.name_len_count;
                     end
                     nxt_state = '0;
                  end
               end
            end
            default: begin
               emit = 1'b1;
               rsp.kind = socks_pkg::KIND_FINAL;
               rsp.status = socks_pkg::ST_BAD_ATYPE;
               nxt_state = '0;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/socks5_request_parser.sv
// socks5_request_parser: top level, input register, parse state and result register
// depends on socks_pkg and socks_step
`timescale 1ns / 1ps

// Parses a SOCKS5 connect request one byte per transaction and, while rsp_stall is
// low, sustains one byte per clock cycle. Each accepted byte lands in an input
// register; once the output register is free the parse logic updates the request
// state and, where the byte causes one, loads a result into the output register.
// Domain name bytes come out as kind 0 results as they arrive (none when the length
// is at or above MAX_HOST_LEN); each complete request ends with one kind 1 result
// carrying status and, where they apply, address kind, IPv4 address, port and name
// length up to the first zero byte. req_restart marks a byte as the first of a new
// request. The output register holds a result while rsp_stall is high; the input
// side stalls only when a byte is waiting and the output register cannot be freed.
module socks5_request_parser #(
   parameter int MAX_HOST_LEN = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic        rsp_addr_kind,
   output logic [31:0] rsp_ipv4_addr,
   output logic [15:0] rsp_dest_port,
   output logic [7:0]  rsp_name_byte,
   output logic [7:0]  rsp_name_length
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_restart_ff;

   // parse state
   socks_pkg::parse_state_type state_ff;
   socks_pkg::parse_state_type state_in;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   socks_pkg::rsp_type rsp_ff;

   socks_pkg::rsp_type step_rsp;
   logic               step_emit;
   logic               out_free;
   logic               advance;
   logic               req_take;

   socks_step #(
      .MAX_HOST_LEN(MAX_HOST_LEN)
   ) u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .nxt_state (state_in),
      .emit      (step_emit),
      .rsp       (step_rsp)
   );

   // output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // held byte is processed this cycle
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
      if (advance && step_emit) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_status      = rsp_ff.status;
   assign rsp_addr_kind   = rsp_ff.addr_kind;
   assign rsp_ipv4_addr   = rsp_ff.ipv4_addr;
   assign rsp_dest_port   = rsp_ff.dest_port;
   assign rsp_name_byte   = rsp_ff.name_byte;
   assign rsp_name_length = rsp_ff.name_length;

   // input stalls only while a byte is held and the result register is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // byte position never runs past the longest domain request
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_pos <= socks_pkg::POS_MAX)
      else $error("byte position out of range");

   // name byte transactions carry only the name byte and the domain address kind
   a_name_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == socks_pkg::KIND_NAME) |->
      (rsp_ff.addr_kind == socks_pkg::AKIND_DOMAIN && rsp_ff.status == socks_pkg::ST_OK &&
       rsp_ff.name_length == 8'd0 && rsp_ff.dest_port == 16'd0))
      else $error("name byte result with stray fields");

   // a final result always leaves the parser at the start of a request
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit && step_rsp.kind == socks_pkg::KIND_FINAL) |=>
      (state_ff.byte_pos == '0))
      else $error("state not cleared after final result");

endmodule

>>> sim/socks5_request_parser_test.sv
// socks5_request_parser_test: self-checking bench for the socks5 request parser
// streams directed and random requests, predicts every result and compares field by field
// depends on socks_pkg and socks5_request_parser
`timescale 1ns / 1ps

module socks5_request_parser_test;

   localparam int MAX_HOST_LEN = 128;
   localparam int BYTE_BUDGET  = 1950;   // stop queueing requests past this many bytes
   localparam int TAIL_BYTES   = 150;    // last bytes are sent with no idling on either side
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off to back the block up

   // kinds of request the random part draws from
   typedef enum int {
      REQ_IPV4, REQ_IPV4_ZERO, REQ_DOMAIN, REQ_DOMAIN_LONG,
      REQ_IPV6, REQ_BAD_ATYPE, REQ_BROKEN, REQ_DOMAIN_NUL
   } req_class_type;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } req_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [2:0]  rsp_status;
   logic        rsp_addr_kind;
   logic [31:0] rsp_ipv4_addr;
   logic [15:0] rsp_dest_port;
   logic [7:0]  rsp_name_byte;
   logic [7:0]  rsp_name_length;

   req_byte_type               bytes_to_send[$];
   socks_pkg::rsp_type         rsp_due[$];
   socks_pkg::parse_state_type ps = '0;

   int   bytes_total = 0;
   int   bytes_taken = 0;
   int   mismatch_count = 0;
   logic req_taken = 1'b0;
   logic tail_phase = 1'b0;
   logic hold_long = 1'b0;
   logic restart_next = 1'b0;
   int   send_gap = 0;
   int   send_idle_pct = 0;
   int   launch_count = 0;
   int   stall_left = 0;
   int   recv_idle_pct = 0;
   int   recv_cycle = 0;

   socks5_request_parser #(
      .MAX_HOST_LEN(MAX_HOST_LEN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_addr_kind  (rsp_addr_kind),
      .rsp_ipv4_addr  (rsp_ipv4_addr),
      .rsp_dest_port  (rsp_dest_port),
      .rsp_name_byte  (rsp_name_byte),
      .rsp_name_length(rsp_name_length)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // parse one accepted byte and queue the results it causes
   task automatic parse_byte(input logic [7:0] b, input logic rs);
      socks_pkg::rsp_type r;
      int                 p;
      int                 dlen;
      r = '0;
      if (rs)
         ps = '0;
      p = int'(ps.byte_pos);
      dlen = int'(ps.domain_count);
      if (p < 4) begin
         if (p == 1)
            ps.command_code = b;
         else if (p == 3)
            ps.atype_code = b;
         ps.byte_pos = socks_pkg::POS_W'(p + 1);
      end else if (ps.atype_code == socks_pkg::ATYPE_IPV4) begin
         if (p <= 7)
            ps.address_accum = {ps.address_accum[23:0], b};
         else
            ps.port_accum = {ps.port_accum[7:0], b};
         if (p < 9) begin
            ps.byte_pos = socks_pkg::POS_W'(p + 1);
         end else begin
            r.kind = socks_pkg::KIND_FINAL;
            r.addr_kind = socks_pkg::AKIND_IPV4;
            r.ipv4_addr = ps.address_accum;
            r.dest_port = ps.port_accum;
            if (ps.address_accum == 32'd0 || ps.port_accum == 16'd0)
               r.status = socks_pkg::ST_ZERO_ADDR;
            else if (ps.command_code != socks_pkg::CMD_CONNECT)
               r.status = socks_pkg::ST_BAD_CMD;
            else
               r.status = socks_pkg::ST_OK;
            rsp_due.push_back(r);
            ps = '0;
         end
      end else if (ps.atype_code == socks_pkg::ATYPE_IPV6) begin
         // address and port are swallowed, only the status comes out
         if (p < 21) begin
            ps.byte_pos = socks_pkg::POS_W'(p + 1);
         end else begin
            r.kind = socks_pkg::KIND_FINAL;
            r.status = socks_pkg::ST_IPV6;
            rsp_due.push_back(r);
            ps = '0;
         end
      end else if (ps.atype_code == socks_pkg::ATYPE_DOMAIN) begin
         if (p == 4) begin
            ps.domain_count = b;
            ps.byte_pos = socks_pkg::POS_W'(5);
         end else if (p <= 4 + dlen) begin
            ps.byte_pos = socks_pkg::POS_W'(p + 1);
            if (dlen < MAX_HOST_LEN) begin
               // name length stops counting at the first nul
               if (!ps.zero_byte_seen) begin
                  if (b == 8'h00)
                     ps.zero_byte_seen = 1'b1;
                  else
                     ps.name_len_count = ps.name_len_count + 8'd1;
               end
               r.kind = socks_pkg::KIND_NAME;
               r.addr_kind = socks_pkg::AKIND_DOMAIN;
               r.name_byte = b;
               rsp_due.push_back(r);
            end
         end else begin
            ps.port_accum = {ps.port_accum[7:0], b};
            if (p < 6 + dlen) begin
               ps.byte_pos = socks_pkg::POS_W'(p + 1);
            end else begin
               r.kind = socks_pkg::KIND_FINAL;
               r.addr_kind = socks_pkg::AKIND_DOMAIN;
               r.dest_port = ps.port_accum;
               if (dlen >= MAX_HOST_LEN) begin
                  r.status = socks_pkg::ST_BAD_DOMAIN;
               end else begin
                  r.status = (ps.command_code != socks_pkg::CMD_CONNECT) ?
                             socks_pkg::ST_BAD_CMD : socks_pkg::ST_OK;
                  r.name_length = ps.name_len_count;
               end
               rsp_due.push_back(r);
               ps = '0;
            end
         end
      end else begin
         r.kind = socks_pkg::KIND_FINAL;
         r.status = socks_pkg::ST_BAD_ATYPE;
         rsp_due.push_back(r);
         ps = '0;
      end
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", fname, want, got);
         mismatch_count++;
      end
   endtask

   task automatic push_byte(input logic [7:0] d, input logic rs);
      req_byte_type t;
      t.data = d;
      t.restart = rs;
      bytes_to_send.push_back(t);
   endtask

   // build one request of the given class with random content
   task automatic queue_request(input req_class_type cls);
      logic [7:0] body[$];
      logic [7:0] atype;
      int         n;
      int         z;
      int         keep;
      body.push_back(8'($urandom));
      body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : socks_pkg::CMD_CONNECT);
      body.push_back(8'($urandom));
      case (cls)
         REQ_IPV4, REQ_IPV4_ZERO: begin
            body.push_back(socks_pkg::ATYPE_IPV4);
            repeat (6) body.push_back(8'($urandom));
            if (cls == REQ_IPV4_ZERO) begin
               z = $urandom_range(0, 2);
               if (z != 1)
                  for (int i = 4; i < 8; i++) body[i] = 8'h00;
               if (z != 0) begin
                  body[8] = 8'h00;
                  body[9] = 8'h00;
               end
            end
         end
         REQ_DOMAIN, REQ_DOMAIN_LONG, REQ_DOMAIN_NUL: begin
            if (cls == REQ_DOMAIN_LONG)
               n = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(MAX_HOST_LEN, 136);
            else if (cls == REQ_DOMAIN_NUL)
               n = $urandom_range(1, 10);
            else if ($urandom_range(0, 9) == 0)
               n = MAX_HOST_LEN - 1;
            else
               n = $urandom_range(0, 12);
            body.push_back(socks_pkg::ATYPE_DOMAIN);
            body.push_back(8'(n));
            repeat (n) body.push_back(8'($urandom_range(1, 255)));
            if (cls == REQ_DOMAIN_NUL)
               body[5 + $urandom_range(0, n - 1)] = 8'h00;
            if ($urandom_range(0, 7) == 0) begin
               body.push_back(8'h00);
               body.push_back(8'h00);
            end else begin
               body.push_back(8'($urandom));
               body.push_back(8'($urandom));
            end
         end
         REQ_IPV6: begin
            body.push_back(socks_pkg::ATYPE_IPV6);
            repeat (18) body.push_back(8'($urandom));
         end
         REQ_BAD_ATYPE: begin
            atype = 8'($urandom);
            if (atype == socks_pkg::ATYPE_IPV4 || atype == socks_pkg::ATYPE_DOMAIN ||
                atype == socks_pkg::ATYPE_IPV6)
               atype = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
            body.push_back(atype);
            body.push_back(8'($urandom));
         end
         default: begin
            // a request cut short; the next one starts with restart
            case ($urandom_range(0, 2))
               0:       body.push_back(socks_pkg::ATYPE_IPV4);
               1:       body.push_back(socks_pkg::ATYPE_DOMAIN);
               default: body.push_back(socks_pkg::ATYPE_IPV6);
            endcase
            repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
            keep = $urandom_range(1, body.size());
            while (body.size() > keep) void'(body.pop_back());
         end
      endcase
      foreach (body[i])
         push_byte(body[i], (i == 0) && (restart_next || $urandom_range(0, 1) == 1));
      restart_next = (cls == REQ_BROKEN);
   endtask

   function automatic req_class_type pick_class();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)      return REQ_IPV4;
      else if (roll < 38) return REQ_IPV4_ZERO;
      else if (roll < 66) return REQ_DOMAIN;
      else if (roll < 70) return REQ_DOMAIN_LONG;
      else if (roll < 76) return REQ_IPV6;
      else if (roll < 82) return REQ_BAD_ATYPE;
      else if (roll < 90) return REQ_BROKEN;
      else                return REQ_DOMAIN_NUL;
   endfunction

   // stimulus, reset and end of run
   initial begin : stimulus
      logic [7:0] directed_bytes[24];
      int         k;
      int         guard;
      // ipv4 connect at all ones, unknown atype, short domain with nul, bad cmd, zero port
      directed_bytes = '{8'h05, socks_pkg::CMD_CONNECT, 8'h00, socks_pkg::ATYPE_IPV4,
                         8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                         8'h05, socks_pkg::CMD_CONNECT, 8'h00, 8'hff, 8'h00,
                         8'h05, 8'h00, 8'h00, socks_pkg::ATYPE_DOMAIN, 8'h02, 8'h61,
                         8'h00, 8'h00, 8'h00};
      foreach (directed_bytes[i])
         push_byte(directed_bytes[i], i == 0);
      // first pass walks every request class once, then draw at random
      k = 0;
      while (bytes_to_send.size() < BYTE_BUDGET) begin
         queue_request((k < 8) ? req_class_type'(k) : pick_class());
         k++;
      end
      bytes_total = bytes_to_send.size();

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (bytes_taken == bytes_total);
      guard = 0;
      while (rsp_due.size() != 0 && guard < 4000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (rsp_due.size() != 0)
         $error("%0d results never arrived", rsp_due.size());
      if (mismatch_count == 0 && rsp_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // one long receiver hold-off so the parser fills up and stalls its input
   initial begin : long_hold
      wait (bytes_taken >= 400);
      @(posedge clock);
      hold_long <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_long <= 1'b0;
   end

   // request driver: holds each byte until accepted, idles in random bursts
   always @(negedge clock) begin : driver
      req_byte_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0 && !tail_phase) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (bytes_to_send.size() != 0) begin
            nb = bytes_to_send.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nb.data;
            req_restart <= nb.restart;
            launch_count <= launch_count + 1;
            if (launch_count % 64 == 0)
               send_idle_pct <= 15 * $urandom_range(0, 2);
            if (!tail_phase && $urandom_range(0, 99) < send_idle_pct)
               send_gap <= $urandom_range(1, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stall bursts, plus the long hold-off
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         recv_cycle <= recv_cycle + 1;
         if (recv_cycle % 128 == 0)
            recv_idle_pct <= 15 * $urandom_range(0, 2);
         if (hold_long) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0 && !tail_phase) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!tail_phase && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 15);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: predicts on every accepted byte, checks every accepted result
   always @(posedge clock) begin : monitor
      socks_pkg::rsp_type want;
      if (reset) begin
         ps = '0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         tail_phase <= (bytes_taken + TAIL_BYTES >= bytes_total);
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_restart);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               $error("result with nothing expected: kind %0d status %0d",
                      rsp_kind, rsp_status);
               mismatch_count++;
            end else begin
               want = rsp_due.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("addr_kind", 32'(want.addr_kind), 32'(rsp_addr_kind));
               check_field("ipv4_addr", want.ipv4_addr, rsp_ipv4_addr);
               check_field("dest_port", 32'(want.dest_port), 32'(rsp_dest_port));
               check_field("name_byte", 32'(want.name_byte), 32'(rsp_name_byte));
               check_field("name_length", 32'(want.name_length), 32'(rsp_name_length));
            end
         end
      end
   end

endmodule

>>> filelist.f
rtl/core/socks_pkg.sv
rtl/core/socks_step.sv
rtl/core/socks5_request_parser.sv
sim/socks5_request_parser_test.sv
